>>> rtl/core/periodic_line_sine_setpoint_unit_macros.svh
// Assertion macros of the setpoint unit checker.
`ifndef PERIODIC_LINE_SINE_SETPOINT_UNIT_MACROS_SVH
`define PERIODIC_LINE_SINE_SETPOINT_UNIT_MACROS_SVH

// Clocked on i_clk, off while i_rst_n is low.
`define PLSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Plain implication on top of PLSU_ASSERT.
`define PLSU_ASSERT_IMP(lbl, ante, cons, msg) \
    `PLSU_ASSERT(lbl, ante |-> cons, msg)

`endif

>>> rtl/core/plsu_pkg.sv
// Package: constants, types and sine table function of the setpoint unit.
`default_nettype none
package plsu_pkg;

    localparam int PLSU_TW         = 32;           // time sample width
    localparam int PLSU_VW         = 48;           // packed vector width
    localparam int PLSU_CW         = 16;           // vector component width
    localparam int PLSU_OW         = 24;           // result field width
    localparam int PLSU_SINE_BITS  = 10;
    localparam int PLSU_DIV_STEPS  = PLSU_TW;
    localparam int PLSU_LATENCY    = PLSU_DIV_STEPS + 8;

    localparam logic [31:0] PLSU_MIN_PERIOD = 32'd262144;
    localparam logic [31:0] PLSU_RST_PERIOD = 32'd655360;
    localparam logic [31:0] PLSU_ONE_SEC    = 32'd65536;

    // register indexes
    localparam logic [2:0] PLSU_REG_INIT_POS = 3'd0;
    localparam logic [2:0] PLSU_REG_LINE_VEL = 3'd1;
    localparam logic [2:0] PLSU_REG_NORM_AMP = 3'd2;
    localparam logic [2:0] PLSU_REG_NORM_DIR = 3'd3;
    localparam logic [2:0] PLSU_REG_PERIOD   = 3'd4;
    localparam logic [2:0] PLSU_REG_DURATION = 3'd5;

    typedef struct packed {
        logic vld;
        logic up;      // ramp up, u below one second
        logic cruise;
        logic neg;     // return half, velocity negated
        logic zero;    // past duration, velocity forced to zero
    } t_ctl;

    // sin(pi/2 * idx / 2^bits) in Q15 by a truncated series, elaboration only
    function automatic logic [15:0] sine_entry(input int unsigned idx, input int unsigned bits);
        longint unsigned a;
        longint unsigned a2;
        longint unsigned term;
        longint          sum;
        a    = (64'd1686629713 * 64'(idx)) >> bits;
        a2   = (a * a) >> 30;
        term = a;
        sum  = longint'(a);
        term = ((term * a2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * a2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * a2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * a2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * a2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * a2) >> 30) / 156;
        sum  = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 16384) >>> 15;
        if (sum > 32768) begin
            sum = 32768;
        end
        return sum[15:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/plsu_rem.sv
// Pipelined restoring remainder: time sample modulo period, one bit per stage.
`default_nettype none
module plsu_rem import plsu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic [PLSU_TW-1:0] i_num,
    input  logic [PLSU_TW-1:0] i_den,
    output logic               o_vld,
    output logic [PLSU_TW-1:0] o_rem,
    output logic [PLSU_TW-1:0] o_num
);

    logic               r_vld [0:PLSU_DIV_STEPS];
    logic [PLSU_TW-1:0] r_rem [0:PLSU_DIV_STEPS];
    logic [PLSU_TW-1:0] r_num [0:PLSU_DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        r_rem[0] <= '0;
        r_num[0] <= i_num;
    end

    for (genvar j = 1; j <= PLSU_DIV_STEPS; j++) begin : g_step
        logic [PLSU_TW:0] w_trial;
        logic [PLSU_TW:0] w_diff;
        logic             w_fit;

        assign w_trial = {r_rem[j-1], r_num[j-1][PLSU_TW-j]};
        assign w_diff  = w_trial - {1'b0, i_den};
        assign w_fit   = (w_trial >= {1'b0, i_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= r_vld[j-1];
            end
            r_rem[j] <= w_fit ? w_diff[PLSU_TW-1:0] : w_trial[PLSU_TW-1:0];
            r_num[j] <= r_num[j-1];
        end
    end

    assign o_vld = r_vld[PLSU_DIV_STEPS];
    assign o_rem = r_rem[PLSU_DIV_STEPS];
    assign o_num = r_num[PLSU_DIV_STEPS];

endmodule
`default_nettype wire

>>> rtl/core/plsu_sine.sv
// Quarter-wave sine table: sine and cosine of the time fraction; the table value is registered, then the signed result.
`default_nettype none
module plsu_sine import plsu_pkg::*; #(
    parameter int SINE_TABLE_BITS = PLSU_SINE_BITS
) (
    input  logic               i_clk,
    input  logic [15:0]        i_phase,
    output logic signed [16:0] o_sin,
    output logic signed [16:0] o_cos
);

    localparam int N = 1 << SINE_TABLE_BITS;

    logic [15:0]              w_tab [0:N];
    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [1:0]               w_qs;
    logic [1:0]               w_qc;
    logic [SINE_TABLE_BITS:0] w_as;
    logic [SINE_TABLE_BITS:0] w_ac;
    logic [15:0]              r_ms;
    logic [15:0]              r_mc;
    logic                     r_ns;
    logic                     r_nc;

    for (genvar g = 0; g <= N; g++) begin : g_tab
        assign w_tab[g] = sine_entry(g, SINE_TABLE_BITS);
    end

    assign w_idx = i_phase[13 -: SINE_TABLE_BITS];
    assign w_qs  = i_phase[15:14];
    assign w_qc  = i_phase[15:14] + 2'd1;   // cosine: quarter turn ahead
    assign w_as  = w_qs[0] ? (SINE_TABLE_BITS+1)'(N) - {1'b0, w_idx} : {1'b0, w_idx};
    assign w_ac  = w_qc[0] ? (SINE_TABLE_BITS+1)'(N) - {1'b0, w_idx} : {1'b0, w_idx};

    always_ff @(posedge i_clk) begin
        r_ms  <= w_tab[w_as];
        r_mc  <= w_tab[w_ac];
        r_ns  <= w_qs[1];
        r_nc  <= w_qc[1];
        o_sin <= r_ns ? -$signed({1'b0, r_ms}) : $signed({1'b0, r_ms});
        o_cos <= r_nc ? -$signed({1'b0, r_mc}) : $signed({1'b0, r_mc});
    end

endmodule
`default_nettype wire

>>> rtl/core/plsu_axis.sv
// One Cartesian component: line profile, sine overlay, offset, saturation.
`default_nettype none
module plsu_axis import plsu_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_ctl                       i_ctl,
    input  logic [15:0]                i_w,     // ramp time, u or h-u
    input  logic [31:0]                i_u,
    input  logic [31:0]                i_span,  // 2h - 2 s
    input  logic signed [16:0]         i_s,
    input  logic signed [16:0]         i_c,
    input  logic signed [PLSU_CW-1:0]  i_v,
    input  logic signed [PLSU_CW-1:0]  i_a,
    input  logic signed [PLSU_CW-1:0]  i_n,
    input  logic signed [PLSU_CW-1:0]  i_p0,
    output logic                       o_vld,
    output logic signed [PLSU_OW-1:0]  o_pos,
    output logic signed [PLSU_OW-1:0]  o_vel
);

    // stage 1: first products
    logic signed [16:0] w_ws;
    logic signed [33:0] w_crd;
    logic signed [32:0] w_spn;
    t_ctl               r1_ctl;
    logic signed [32:0] r1_vw;
    logic        [31:0] r1_ww;
    logic signed [49:0] r1_cr;
    logic signed [48:0] r1_bs;
    logic signed [32:0] r1_as;
    logic signed [32:0] r1_ac;
    logic signed [22:0] r1_on;

    assign w_ws  = $signed({1'b0, i_w});
    assign w_crd = $signed({1'b0, i_u, 1'b0}) - 34'sd65536;
    assign w_spn = $signed({1'b0, i_span});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else begin
            r1_ctl <= i_ctl;
        end
        r1_vw <= i_v * w_ws;
        r1_ww <= i_w * i_w;
        r1_cr <= i_v * w_crd;
        r1_bs <= i_v * w_spn;
        r1_as <= i_a * i_s;
        r1_ac <= i_a * i_c;
        r1_on <= i_n * 7'sd41;       // 0.01 in 1/4096
    end

    // stage 2: second products
    t_ctl               r2_ctl;
    logic signed [48:0] r2_vww;
    logic signed [47:0] r2_asw;
    logic signed [32:0] r2_vw;
    logic signed [49:0] r2_cr;
    logic signed [48:0] r2_bs;
    logic signed [32:0] r2_ac;
    logic signed [22:0] r2_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else begin
            r2_ctl <= r1_ctl;
        end
        r2_vww <= i_v * $signed({1'b0, r1_ww});
        r2_asw <= r1_as * 16'sd25736; // 2*pi in 1/4096
        r2_vw  <= r1_vw;
        r2_cr  <= r1_cr;
        r2_bs  <= r1_bs;
        r2_ac  <= r1_ac;
        r2_on  <= r1_on;
    end

    // stage 3: direction sign and rounding, half toward +inf
    logic signed [33:0] w_qvw;
    logic signed [49:0] w_qsq;
    logic signed [50:0] w_qcr;
    logic signed [49:0] w_qbs;
    logic signed [33:0] w_tvw;
    logic signed [49:0] w_tsq;
    logic signed [50:0] w_tcr;
    logic signed [49:0] w_tbp;
    logic signed [49:0] w_tbv;
    logic signed [47:0] w_tsv;
    logic signed [32:0] w_tsc;
    logic signed [22:0] w_tso;
    logic signed [17:0] w_vneg;
    t_ctl               r3_ctl;
    logic signed [17:0] r3_lv;
    logic signed [16:0] r3_sq;
    logic signed [33:0] r3_cr;
    logic signed [32:0] r3_bp;
    logic signed [32:0] r3_bv;
    logic signed [20:0] r3_sv;
    logic signed [17:0] r3_sc;
    logic signed [10:0] r3_so;

    assign w_qvw  = r2_ctl.neg ? -34'(r2_vw)  : 34'(r2_vw);
    assign w_qsq  = r2_ctl.neg ? -50'(r2_vww) : 50'(r2_vww);
    assign w_qcr  = r2_ctl.neg ? -51'(r2_cr)  : 51'(r2_cr);
    assign w_qbs  = r2_ctl.neg ? -50'(r2_bs)  : 50'(r2_bs);
    assign w_vneg = r2_ctl.neg ? -18'(i_v)    : 18'(i_v);
    assign w_tvw  = w_qvw + 34'sd32768;
    assign w_tsq  = w_qsq + 50'sd4294967296;
    assign w_tcr  = w_qcr + 51'sd65536;
    assign w_tbp  = w_qbs + 50'sd65536;
    assign w_tbv  = 50'(r2_bs) + 50'sd65536;
    assign w_tsv  = r2_asw + 48'sd67108864;
    assign w_tsc  = r2_ac + 33'sd16384;
    assign w_tso  = r2_on + 23'sd2048;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else begin
            r3_ctl <= r2_ctl;
        end
        r3_lv <= r2_ctl.cruise ? w_vneg : $signed(w_tvw[33:16]);
        r3_sq <= $signed(w_tsq[49:33]);
        r3_cr <= $signed(w_tcr[50:17]);
        r3_bp <= $signed(w_tbp[49:17]);
        r3_bv <= $signed(w_tbv[49:17]);
        r3_sv <= $signed(w_tsv[47:27]);
        r3_sc <= $signed(w_tsc[32:15]);
        r3_so <= $signed(w_tso[22:12]);
    end

    // stage 4: line position, offsets, velocity sum
    logic signed [35:0] w_sel;
    t_ctl               r4_ctl;
    logic signed [35:0] r4_lp;
    logic signed [19:0] r4_off;
    logic signed [21:0] r4_vel;

    always_comb begin
        if (r3_ctl.up) begin
            w_sel = 36'(r3_sq);
        end else if (r3_ctl.cruise) begin
            w_sel = 36'(r3_cr);
        end else begin
            w_sel = 36'(r3_bp) - 36'(r3_sq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl <= '0;
        end else begin
            r4_ctl <= r3_ctl;
        end
        r4_lp  <= w_sel + (r3_ctl.neg ? 36'(r3_bv) : 36'sd0);
        r4_off <= 20'(i_p0) - 20'(r3_sc) - 20'(i_a) - 20'(r3_so);
        r4_vel <= 22'(r3_lv) + 22'(r3_sv);
    end

    // stage 5: saturate and register the result
    logic signed [36:0] w_pos;
    logic               r5_vld;

    assign w_pos = 37'(r4_lp) + 37'(r4_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_ctl.vld;
        end
        if (w_pos > 37'sd8388607) begin
            o_pos <= 24'sh7FFFFF;
        end else if (w_pos < -37'sd8388608) begin
            o_pos <= 24'sh800000;
        end else begin
            o_pos <= w_pos[PLSU_OW-1:0];
        end
        o_vel <= r4_ctl.zero ? 24'sd0 : 24'(r4_vel);
    end

    assign o_vld = r5_vld;

endmodule
`default_nettype wire

>>> rtl/core/periodic_line_sine_setpoint_unit.sv
// Top level of the periodic line setpoint unit with sine overlay.
//
// Usage:
//  - Input: raise start with a Q16.16 time sample on i_time_now. The sample
//    is taken at a rising edge where start is high and busy is low. busy is
//    low whenever reset is released, so one sample can transfer every cycle while start is high.
//  - Output: one setpoint per sample. o_valid is high for exactly one cycle
//    with position and velocity fields; the receiver must take it then.
//  - Throughput: one sample per clock.
//  - The latency is set by an input register and the 32-stage time-modulo-
//    period remainder pipeline (one quotient bit per stage), followed by two
//    phase stages and five arithmetic stages per axis (products, rounding,
//    sums, saturation).
//  - Configuration: i_cfg_we / i_cfg_idx / i_cfg_data write one register per
//    edge; write only while no sample is in flight. Period is clamped to
//    at least 4 s when written.
//  - Reset (i_rst_n low, synchronous): registers return to defaults (period
//    10 s, duration max) and every in-flight sample is dropped.
//  - The receiver has no stall; results simply leave the pipeline.
`default_nettype none
module periodic_line_sine_setpoint_unit import plsu_pkg::*; #(
    parameter int SINE_TABLE_BITS = PLSU_SINE_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [PLSU_TW-1:0]         i_time_now,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [PLSU_VW-1:0]         i_cfg_data,
    output logic                       o_valid,
    output logic signed [PLSU_OW-1:0]  o_pos_x,
    output logic signed [PLSU_OW-1:0]  o_pos_y,
    output logic signed [PLSU_OW-1:0]  o_pos_z,
    output logic signed [PLSU_OW-1:0]  o_vel_x,
    output logic signed [PLSU_OW-1:0]  o_vel_y,
    output logic signed [PLSU_OW-1:0]  o_vel_z
);

    // ---------------- configuration registers ----------------
    logic [PLSU_VW-1:0] r_init;
    logic [PLSU_VW-1:0] r_lvel;
    logic [PLSU_VW-1:0] r_namp;
    logic [PLSU_VW-1:0] r_ndir;
    logic [31:0]        r_period;   // already clamped to the 4 s minimum
    logic [31:0]        r_dur;
    logic [31:0]        w_wr_per;

    assign w_wr_per = (i_cfg_data[31:0] < PLSU_MIN_PERIOD) ? PLSU_MIN_PERIOD
                                                           : i_cfg_data[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init   <= '0;
            r_lvel   <= '0;
            r_namp   <= '0;
            r_ndir   <= '0;
            r_period <= PLSU_RST_PERIOD;
            r_dur    <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                PLSU_REG_INIT_POS: r_init   <= i_cfg_data;
                PLSU_REG_LINE_VEL: r_lvel   <= i_cfg_data;
                PLSU_REG_NORM_AMP: r_namp   <= i_cfg_data;
                PLSU_REG_NORM_DIR: r_ndir   <= i_cfg_data;
                PLSU_REG_PERIOD:   r_period <= w_wr_per;
                PLSU_REG_DURATION: r_dur    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // half period and derived spans: kept static while samples are in flight by the user alone
    logic [31:0] w_h;
    logic [31:0] w_hms;     // h - 1 s, end of cruise
    logic [31:0] w_span;    // 2h - 2 s

    assign w_h    = {1'b0, r_period[31:1]};
    assign w_hms  = w_h - PLSU_ONE_SEC;
    assign w_span = {r_period[31:1], 1'b0} - {PLSU_ONE_SEC[30:0], 1'b0};

    // ---------------- input transfer ----------------
    logic w_take;

    assign busy   = ~i_rst_n;
    assign w_take = start & ~busy;

    // ---------------- t = T mod P ----------------
    logic               w_rm_vld;
    logic [PLSU_TW-1:0] w_rm_t;
    logic [PLSU_TW-1:0] w_rm_tim;

    plsu_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_take),
        .i_num   (i_time_now),
        .i_den   (r_period),
        .o_vld   (w_rm_vld),
        .o_rem   (w_rm_t),
        .o_num   (w_rm_tim)
    );

    // ---------------- sine / cosine of the time fraction ----------------
    logic signed [16:0] w_sin;
    logic signed [16:0] w_cos;

    plsu_sine #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine (
        .i_clk   (i_clk),
        .i_phase (w_rm_tim[15:0]),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // ---------------- phase stage 1: pick the half ----------------
    logic        r_p1_vld;
    logic        r_p1_hi;
    logic        r_p1_zero;
    logic [31:0] r_p1_u;
    logic        w_hi;

    assign w_hi = (w_rm_t > w_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else begin
            r_p1_vld <= w_rm_vld;
        end
        r_p1_hi   <= w_hi;
        r_p1_u    <= w_hi ? (w_rm_t - w_h) : w_rm_t;
        r_p1_zero <= (w_rm_tim >= r_dur);
    end

    // ---------------- phase stage 2: region within the half ----------------
    logic        w_up;
    logic [31:0] w_d;
    t_ctl        r_p2_ctl;
    logic [15:0] r_p2_w;
    logic [31:0] r_p2_u;

    assign w_up = (r_p1_u < PLSU_ONE_SEC);
    assign w_d  = w_h - r_p1_u;   // below 1 s on the ramp down

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_ctl <= '0;
        end else begin
            r_p2_ctl.vld    <= r_p1_vld;
            r_p2_ctl.up     <= w_up;
            r_p2_ctl.cruise <= ~w_up & (r_p1_u <= w_hms);
            r_p2_ctl.neg    <= r_p1_hi;
            r_p2_ctl.zero   <= r_p1_zero;
        end
        r_p2_w <= w_up ? r_p1_u[15:0] : w_d[15:0];
        r_p2_u <= r_p1_u;
    end

    // ---------------- per-axis arithmetic ----------------
    logic                      w_vld [3];
    logic signed [PLSU_OW-1:0] w_pos [3];
    logic signed [PLSU_OW-1:0] w_vel [3];

    for (genvar k = 0; k < 3; k++) begin : g_axis
        plsu_axis u_axis (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (r_p2_ctl),
            .i_w     (r_p2_w),
            .i_u     (r_p2_u),
            .i_span  (w_span),
            .i_s     (w_sin),
            .i_c     (w_cos),
            .i_v     ($signed(r_lvel[PLSU_CW*k +: PLSU_CW])),
            .i_a     ($signed(r_namp[PLSU_CW*k +: PLSU_CW])),
            .i_n     ($signed(r_ndir[PLSU_CW*k +: PLSU_CW])),
            .i_p0    ($signed(r_init[PLSU_CW*k +: PLSU_CW])),
            .o_vld   (w_vld[k]),
            .o_pos   (w_pos[k]),
            .o_vel   (w_vel[k])
        );
    end

    // all three axes run in lockstep
    assign o_valid = w_vld[0] & w_vld[1] & w_vld[2];
    assign o_pos_x = w_pos[0];
    assign o_pos_y = w_pos[1];
    assign o_pos_z = w_pos[2];
    assign o_vel_x = w_vel[0];
    assign o_vel_y = w_vel[1];
    assign o_vel_z = w_vel[2];

endmodule
`default_nettype wire

>>> rtl/core/plsu_chk.sv
// Port-level checker of the setpoint unit, bound to the top level.
`include "periodic_line_sine_setpoint_unit_macros.svh"
`default_nettype none
module plsu_chk import plsu_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [PLSU_TW-1:0]        i_time_now,
    input logic                      i_cfg_we,
    input logic [2:0]                i_cfg_idx,
    input logic [PLSU_VW-1:0]        i_cfg_data,
    input logic                      o_valid,
    input logic signed [PLSU_OW-1:0] o_vel_x,
    input logic signed [PLSU_OW-1:0] o_vel_y,
    input logic signed [PLSU_OW-1:0] o_vel_z
);

    // shadow of the duration register
    logic [31:0] r_dur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur <= '1;
        end else if (i_cfg_we && (i_cfg_idx == PLSU_REG_DURATION)) begin
            r_dur <= i_cfg_data[31:0];
        end
    end

    `PLSU_ASSERT_IMP(a_result_follows, start && !busy, ##PLSU_LATENCY o_valid, "sample lost")
    `PLSU_ASSERT_IMP(a_no_extra_result, o_valid, $past(start && !busy, PLSU_LATENCY), "spurious result")
    `PLSU_ASSERT_IMP(a_vel_zero_after_dur, o_valid && $past(start && !busy && (i_time_now >= r_dur), PLSU_LATENCY), o_vel_x == 0 && o_vel_y == 0 && o_vel_z == 0, "velocity not zero past duration")

endmodule

bind periodic_line_sine_setpoint_unit plsu_chk u_chk (.*);
`default_nettype wire

>>> tb/periodic_line_sine_setpoint_unit_tb.sv
// Self-checking testbench of the periodic line setpoint unit with sine overlay.
`timescale 1ns / 100ps
`default_nettype none
module periodic_line_sine_setpoint_unit_tb;
    import plsu_pkg::*;

    localparam int TAB_BITS = PLSU_SINE_BITS;
    localparam int TAB_N    = (1 << TAB_BITS) + 1;

    // one expected or observed setpoint
    typedef struct packed {
        logic signed [23:0] px, py, pz, vx, vy, vz;
    } t_setpoint;

    // Scoreboard: holds its own copy of the registers, predicts each setpoint
    // at the accepting edge and checks results in order.
    class setpoint_board;
        logic [47:0]  init_pos, line_vel, norm_amp, norm_dir;
        logic [31:0]  period, duration;
        longint       sine_q15_tab[TAB_N];
        t_setpoint    pending[$];
        int           mismatches;

        function new();
            longint unsigned a, a2, term;
            longint          sum;
            init_pos = '0; line_vel = '0; norm_amp = '0; norm_dir = '0;
            period = PLSU_RST_PERIOD; duration = 32'hFFFF_FFFF;
            mismatches = 0;
            // quarter-wave table from a truncated odd series
            for (int i = 0; i < TAB_N; i++) begin
                a    = (64'd1686629713 * 64'(i)) >> TAB_BITS;
                a2   = (a * a) >> 30;
                term = a;
                sum  = longint'(a);
                for (int k = 1; k <= 6; k++) begin
                    term = ((term * a2) >> 30) / longint'((2 * k) * (2 * k + 1));
                    if (k % 2 == 1) sum -= longint'(term);
                    else            sum += longint'(term);
                end
                if (sum < 0) sum = 0;
                sum = (sum + 16384) >>> 15;
                if (sum > 32768) sum = 32768;
                sine_q15_tab[i] = sum;
            end
        endfunction

        // round half toward +inf: floor((x + half) / 2^s)
        function longint rnd_shift(longint x, int s);
            return (x + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint sine_at(logic [31:0] ph);
            logic [1:0] quad;
            int         idx;
            longint     m;
            quad = ph[15:14];
            idx  = int'(ph[13:0]) >> (14 - TAB_BITS);
            m    = quad[0] ? sine_q15_tab[(1 << TAB_BITS) - idx] : sine_q15_tab[idx];
            return quad[1] ? -m : m;
        endfunction

        function longint lane(logic [47:0] r, int k);
            logic signed [15:0] c;
            c = r[16*k +: 16];
            return longint'(c);
        endfunction

        function logic signed [23:0] clip24(longint x);
            if (x > 8388607)  x = 8388607;
            if (x < -8388608) x = -8388608;
            return x[23:0];
        endfunction

        // trapezoid profile inside one half period
        function void half_profile(longint v, longint u, longint h,
                                   output longint lp, output longint lv);
            longint d;
            if (u < 65536) begin
                lp = rnd_shift(v * u * u, 33);
                lv = rnd_shift(v * u, 16);
            end else if (u <= h - 65536) begin
                lp = rnd_shift(v * (2 * u - 65536), 17);
                lv = v;
            end else begin
                d  = h - u;
                lp = rnd_shift(v * (2 * h - 2 * 65536), 17) - rnd_shift(v * d * d, 33);
                lv = rnd_shift(v * d, 16);
            end
        endfunction

        function t_setpoint predict_setpoint(logic [31:0] tn);
            longint    p, t, h, s, c, v, a, n, p0, lp, lv, pos, vel;
            longint    pos_f[3], vel_f[3];
            t_setpoint r;
            p = (period < PLSU_MIN_PERIOD) ? longint'(PLSU_MIN_PERIOD) : longint'(period);
            t = longint'(tn) % p;
            h = p >> 1;
            s = sine_at(tn);
            c = sine_at(tn + 32'd16384);
            for (int k = 0; k < 3; k++) begin
                v  = lane(line_vel, k);
                a  = lane(norm_amp, k);
                n  = lane(norm_dir, k);
                p0 = lane(init_pos, k);
                if (t > h) begin
                    half_profile(-v, t - h, h, lp, lv);
                    lp += rnd_shift(v * (2 * h - 2 * 65536), 17);
                end else begin
                    half_profile(v, t, h, lp, lv);
                end
                pos = p0 + lp - rnd_shift(a * c, 15) - a - rnd_shift(n * 41, 12);
                vel = lv + rnd_shift(a * s * 25736, 27);
                if (tn >= duration) vel = 0;
                pos_f[k] = pos;
                vel_f[k] = vel;
            end
            r.px = clip24(pos_f[0]); r.py = clip24(pos_f[1]); r.pz = clip24(pos_f[2]);
            r.vx = clip24(vel_f[0]); r.vy = clip24(vel_f[1]); r.vz = clip24(vel_f[2]);
            return r;
        endfunction

        function void write_reg(logic [2:0] idx, logic [47:0] d);
            case (idx)
                PLSU_REG_INIT_POS: init_pos = d;
                PLSU_REG_LINE_VEL: line_vel = d;
                PLSU_REG_NORM_AMP: norm_amp = d;
                PLSU_REG_NORM_DIR: norm_dir = d;
                PLSU_REG_PERIOD:   period   = d[31:0];
                PLSU_REG_DURATION: duration = d[31:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [31:0] tn);
            pending.push_back(predict_setpoint(tn));
        endfunction

        function void check_setpoint(t_setpoint got);
            t_setpoint exp_sp;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected setpoint at %0t", $realtime);
                return;
            end
            exp_sp = pending.pop_front();
            if (got != exp_sp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"setpoint mismatch at %0t: exp pos %0d %0d %0d ",
                              "vel %0d %0d %0d, got pos %0d %0d %0d vel %0d %0d %0d"},
                             $realtime, exp_sp.px, exp_sp.py, exp_sp.pz, exp_sp.vx,
                             exp_sp.vy, exp_sp.vz, got.px, got.py, got.pz, got.vx,
                             got.vy, got.vz);
            end
        endfunction
    endclass

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               start      = 1'b0;
    logic               busy;
    logic [31:0]        i_time_now = '0;
    logic               i_cfg_we   = 1'b0;
    logic [2:0]         i_cfg_idx  = '0;
    logic [47:0]        i_cfg_data = '0;
    logic               o_valid;
    logic signed [23:0] o_pos_x, o_pos_y, o_pos_z, o_vel_x, o_vel_y, o_vel_z;

    setpoint_board board;
    int            send_idle_pct;   // chance in percent of an idle cycle after a transfer

    periodic_line_sine_setpoint_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_time_now(i_time_now), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_pos_z(o_pos_z),
        .o_vel_x(o_vel_x), .o_vel_y(o_vel_y), .o_vel_z(o_vel_z)
    );

    always #10 i_clk = ~i_clk;

    // Result side: the strobe holds for one cycle, so sample on every edge.
    always @(posedge i_clk) begin
        t_setpoint got;
        if (i_rst_n && o_valid) begin
            got.px = o_pos_x; got.py = o_pos_y; got.pz = o_pos_z;
            got.vx = o_vel_x; got.vy = o_vel_y; got.vz = o_vel_z;
            board.check_setpoint(got);
        end
    end

    // One time sample transfer; start stays high on return unless idle cycles were inserted,
    // so back-to-back samples never lower and raise it in one step.
    task automatic send_sample(logic [31:0] tn);
        i_time_now <= tn;
        start      <= 1'b1;
        do @(posedge i_clk); while (busy);
        board.note_sample(tn);
        while ($urandom_range(99) < send_idle_pct) begin
            start      <= 1'b0;
            i_time_now <= $urandom;
            @(posedge i_clk);
        end
    endtask

    // Drain the pipeline before touching registers.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (PLSU_LATENCY + 4) @(posedge i_clk);
    endtask

    // Write enable stays high across back-to-back writes; the caller drops it.
    task automatic write_reg(logic [2:0] idx, logic [47:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        board.write_reg(idx, d);
    endtask

    task automatic load_config(logic [47:0] ip, logic [47:0] lv, logic [47:0] na,
                               logic [47:0] nd, logic [31:0] per, logic [31:0] dur);
        write_reg(PLSU_REG_INIT_POS, ip);
        write_reg(PLSU_REG_LINE_VEL, lv);
        write_reg(PLSU_REG_NORM_AMP, na);
        write_reg(PLSU_REG_NORM_DIR, nd);
        write_reg(PLSU_REG_PERIOD,   {16'h0, per});
        write_reg(PLSU_REG_DURATION, {16'h0, dur});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [47:0] rand_vec();
        case ($urandom_range(3))
            0:       return 48'({$urandom, $urandom});
            1:       return {16'($urandom_range(0, 2047) - 1024),
                             16'($urandom_range(0, 2047) - 1024),
                             16'($urandom_range(0, 2047) - 1024)};
            2:       return {16'($urandom_range(0, 16383) - 8192),
                             16'($urandom_range(0, 16383) - 8192),
                             16'($urandom_range(0, 16383) - 8192)};
            default: return {3{16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)}};
        endcase
    endfunction

    // Times mostly land near the profile's corners of some random period.
    function automatic logic [31:0] pick_time();
        longint p, h, off, k;
        p = (board.period < PLSU_MIN_PERIOD) ? longint'(PLSU_MIN_PERIOD)
                                             : longint'(board.period);
        h = p >> 1;
        k = longint'($urandom) % ((longint'(1) << 32) / p + 1);
        case ($urandom_range(6))
            0: return $urandom;
            1: off = $urandom_range(0, 70000);
            2: off = h - 70000 + $urandom_range(0, 140000);
            3: off = h + $urandom_range(0, 70000);
            4: off = p - $urandom_range(1, 70000);
            5: off = h - 65536 + $urandom_range(0, 4) - 2;
            default: off = longint'($urandom) % p;
        endcase
        if (off < 0) off += p;
        return 32'(k * p + off);
    endfunction

    initial begin
        logic [31:0] per_list[8];
        logic [31:0] dir_list[18];
        logic [31:0] dur, h;
        int          n_rand;
        board         = new();
        send_idle_pct = 33;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: corners of a 10 s period, extreme vectors, duration at 20 s.
        load_config({16'h7FFF, 16'h8000, 16'h0001}, {16'h8000, 16'h7FFF, 16'h0FFF},
                    {16'h7FFF, 16'h8000, 16'h0400}, {16'h8000, 16'h7FFF, 16'h1000},
                    PLSU_RST_PERIOD, 32'h0014_0000);
        h = PLSU_RST_PERIOD >> 1;
        dir_list = '{32'h0, 32'hFFFF_FFFF, 32'd65535, 32'd65536, h - 65536, h - 65535,
                     h, h + 1, h + 65535, h + 65536, PLSU_RST_PERIOD - 1,
                     PLSU_RST_PERIOD, 32'd16384, 32'd32768, 32'd49152, 32'h0013_FFFF,
                     32'h0014_0000, 32'h0014_0001};
        foreach (dir_list[i])
            send_sample(dir_list[i]);
        settle();

        // Random phases over period extremes: zero and short clamp, minimum,
        // odd, maximum, and random ones.
        per_list = '{32'd0, 32'd262143, PLSU_MIN_PERIOD, 32'd655361,
                     32'hFFFF_FFFF, $urandom_range(262144, 3000000), $urandom,
                     $urandom_range(262144, 1000000)};
        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct = (ph < 3) ? 33 : (ph < 6) ? 77 : 0;
            case (ph % 4)
                0:       dur = 32'hFFFF_FFFF;
                1:       dur = 32'h0;
                default: dur = $urandom;
            endcase
            load_config(rand_vec(), rand_vec(), rand_vec(), rand_vec(), per_list[ph], dur);
            n_rand = 240;
            for (int i = 0; i < n_rand; i++) send_sample(pick_time());
            settle();
        end

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog well above the slowest correct run.
    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire
